/* src/bafl_pkg.sv */
// Shared types, constants and helpers of the bump allocator with first-fit free list.
package bafl_pkg;

   localparam int DATA_BITS      = 32;
   localparam int PTR_BITS       = 33;
   localparam int CMP_BITS       = 35;
   localparam int STATUS_BITS    = 3;
   localparam int CSR_INDEX_BITS = 8;
   localparam int MAX_BLOCKS_DEF = 64;
   localparam int HEADER_BYTES   = 24;
   localparam int ADDR_BITS      = 32;

   localparam logic [DATA_BITS-1:0] ALIGN_MASK  = 32'd7;
   localparam logic [DATA_BITS-1:0] HEADER_ADDR = DATA_BITS'(HEADER_BYTES);
   localparam logic [CMP_BITS-1:0]  HEADER_CMP  = CMP_BITS'(HEADER_BYTES);
   localparam logic [CMP_BITS-1:0]  ADDR_TOP    = (ADDR_BITS >= 32) ?
                                                  (CMP_BITS'(1) << 32) :
                                                  (CMP_BITS'(1) << ADDR_BITS);

   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_ZERO    = 3'd1;
   localparam status_type ST_OOM     = 3'd2;
   localparam status_type ST_DOUBLE  = 3'd3;
   localparam status_type ST_NULL    = 3'd4;
   localparam status_type ST_UNKNOWN = 3'd5;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAP_START = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAP_BYTES = 8'd1;

   // Address and rounded size of one heap block.
   typedef struct packed {
      logic [DATA_BITS-1:0] addr;
      logic [DATA_BITS-1:0] size;
   } blk_type;

   typedef struct packed {
      logic eq;
      logic ge;
   } cmp_res_type;

   // Round up to a multiple of 8; the carry is kept in the top bit.
   function automatic logic [PTR_BITS-1:0] align8(input logic [DATA_BITS-1:0] x);
      return ({1'b0, x} + {1'b0, ALIGN_MASK}) & ~{1'b0, ALIGN_MASK};
   endfunction

endpackage

/* src/bafl_cmp.sv */
// Shared magnitude and equality comparator used by every scan step of the allocator.
module bafl_cmp (
   input  logic [bafl_pkg::CMP_BITS-1:0] lhs,
   input  logic [bafl_pkg::CMP_BITS-1:0] rhs,
   output bafl_pkg::cmp_res_type         res
);
   import bafl_pkg::*;

   assign res.eq = (lhs == rhs);
   assign res.ge = (lhs >= rhs);

endmodule

/* src/bafl_ram.sv */
// Simple dual-port memory with one write port and one registered read port.
module bafl_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bump_allocator_first_fit_free_list.sv */
// Top level of the heap allocator: bump pointer plus a LIFO free stack searched first fit.
//
// Usage: a request is taken at a clock edge where start is high and busy is low.
// req_op selects allocate or free; req_size is used by allocate and req_user_addr
// by free. Exactly one response follows per request: rsp_valid is high for a
// single cycle with rsp_status, rsp_result_addr and rsp_reused. The receiver
// cannot stall the response, and busy drops in the same cycle the response shows,
// so a new request may be started while a response is on the ports.
// Zero-size allocates, null frees and frees into an empty table answer straight
// from idle. An allocate examines free-stack entries (newest first), then either
// moves each entry above the hit down to close the gap, or places a new block at
// the break pointer. A free examines block-table entries in turn. Both scans are
// paced by the single read port of their memory, so the worst case is a fit at the
// bottom of a full stack.
// Configuration transfers on the csr_ channel are taken only while the block is
// idle and no request is being started; writing either register empties the heap.
// Reset empties the heap and clears both registers. The memories need no clearing:
// only entries below the fill counts are ever read.
module bump_allocator_first_fit_free_list #(
   parameter int MAX_BLOCKS = bafl_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [bafl_pkg::DATA_BITS-1:0]      req_size,
   input  logic [bafl_pkg::DATA_BITS-1:0]      req_user_addr,
   output logic                                rsp_valid,
   output logic [bafl_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [bafl_pkg::DATA_BITS-1:0]      rsp_result_addr,
   output logic                                rsp_reused,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bafl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bafl_pkg::DATA_BITS-1:0]      csr_wdata
);
   import bafl_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);
   localparam int BLK_BITS = $bits(blk_type);
   localparam int TBL_BITS = BLK_BITS + 1;
   localparam int STK_BITS = BLK_BITS + IDX_BITS;
   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_BLOCKS);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ASCAN  = 3'd1;   // walk the free stack from the top
   localparam logic [2:0] S_ASHIFT = 3'd2;   // close the gap left by a reused entry
   localparam logic [2:0] S_NEW    = 3'd3;   // form the end address of a new block
   localparam logic [2:0] S_NCHK   = 3'd4;   // check the end against the window
   localparam logic [2:0] S_FSCAN  = 3'd5;   // walk the block table for a free

   logic [2:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  block_count_ff, block_count_in;
   logic [CNT_BITS-1:0]  free_count_ff, free_count_in;
   logic [PTR_BITS-1:0]  base_ff, base_in;
   logic [DATA_BITS-1:0] bytes_ff, bytes_in;
   logic [PTR_BITS-1:0]  break_ff, break_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [PTR_BITS-1:0]  size_ff, size_in;
   logic [DATA_BITS-1:0] uaddr_ff, uaddr_in;
   logic [IDX_BITS-1:0]  ptr_ff, ptr_in;
   blk_type              hit_ff, hit_in;
   logic [CMP_BITS-1:0]  end_ff, end_in;
   logic [CMP_BITS-1:0]  limit_ff, limit_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic                 rsp_reused_ff, rsp_reused_in;

   logic                 tbl_wr_en;
   logic [IDX_BITS-1:0]  tbl_wr_addr, tbl_rd_addr;
   logic [TBL_BITS-1:0]  tbl_wr_data, tbl_rd_data;
   logic                 stk_wr_en;
   logic [IDX_BITS-1:0]  stk_wr_addr, stk_rd_addr;
   logic [STK_BITS-1:0]  stk_wr_data, stk_rd_data;

   blk_type              tbl_rd_blk, stk_rd_blk;
   logic                 tbl_rd_free;
   logic [IDX_BITS-1:0]  stk_rd_idx;
   logic [CNT_BITS:0]    ptr_nx1, ptr_nx2;

   logic [CMP_BITS-1:0]  cmp_lhs, cmp_rhs;
   cmp_res_type          cmp_res;

   // Block table: address, size and free flag of every block ever placed.
   bafl_ram #(.WIDTH(TBL_BITS), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // Free stack: each entry carries a copy of the block's address and size, which
   // never change once placed, so a scan needs only one memory read per entry.
   bafl_ram #(.WIDTH(STK_BITS), .DEPTH(MAX_BLOCKS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign tbl_rd_blk  = tbl_rd_data[BLK_BITS-1:0];
   assign tbl_rd_free = tbl_rd_data[BLK_BITS];
   assign stk_rd_blk  = stk_rd_data[BLK_BITS-1:0];
   assign stk_rd_idx  = stk_rd_data[STK_BITS-1:BLK_BITS];

   assign ptr_nx1 = (CNT_BITS + 1)'(ptr_ff) + (CNT_BITS + 1)'(1);
   assign ptr_nx2 = (CNT_BITS + 1)'(ptr_ff) + (CNT_BITS + 1)'(2);

   // The one comparator is shared: size fit during the free-stack walk, address
   // match during the block-table walk, and the window limit for a new block.
   always_comb begin
      case (state_ff)
         S_ASCAN: begin
            cmp_lhs = CMP_BITS'(stk_rd_blk.size);
            cmp_rhs = CMP_BITS'(size_ff);
         end
         S_FSCAN: begin
            cmp_lhs = CMP_BITS'(tbl_rd_blk.addr) + HEADER_CMP;
            cmp_rhs = CMP_BITS'(uaddr_ff);
         end
         default: begin
            cmp_lhs = limit_ff;
            cmp_rhs = end_ff;
         end
      endcase
   end

   bafl_cmp u_cmp (
      .lhs (cmp_lhs),
      .rhs (cmp_rhs),
      .res (cmp_res)
   );

   always_comb begin
      state_in       = state_ff;
      block_count_in = block_count_ff;
      free_count_in  = free_count_ff;
      base_in        = base_ff;
      bytes_in       = bytes_ff;
      break_in       = break_ff;
      rsp_valid_in   = 1'b0;
      size_in        = size_ff;
      uaddr_in       = uaddr_ff;
      ptr_in         = ptr_ff;
      hit_in         = hit_ff;
      end_in         = end_ff;
      limit_in       = limit_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_reused_in  = rsp_reused_ff;
      tbl_wr_en      = 1'b0;
      tbl_wr_addr    = ptr_ff;
      tbl_wr_data    = '0;
      tbl_rd_addr    = ptr_ff;
      stk_wr_en      = 1'b0;
      stk_wr_addr    = ptr_ff;
      stk_wr_data    = stk_rd_data;
      stk_rd_addr    = ptr_ff;

      // A configuration write empties the heap; other indexes are ignored.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEAP_START: begin
               base_in        = align8(csr_wdata);
               break_in       = align8(csr_wdata);
               block_count_in = '0;
               free_count_in  = '0;
            end
            CSR_HEAP_BYTES: begin
               bytes_in       = csr_wdata;
               break_in       = base_ff;
               block_count_in = '0;
               free_count_in  = '0;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               size_in  = align8(req_size);
               uaddr_in = req_user_addr;
               if (req_op == OP_ALLOC) begin
                  if (req_size == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_ZERO;
                     rsp_addr_in   = '0;
                     rsp_reused_in = 1'b0;
                  end else if (free_count_ff == '0) begin
                     state_in = S_NEW;
                  end else begin
                     ptr_in      = IDX_BITS'(free_count_ff - 1'b1);
                     stk_rd_addr = IDX_BITS'(free_count_ff - 1'b1);
                     state_in    = S_ASCAN;
                  end
               end else begin
                  if (req_user_addr == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NULL;
                     rsp_addr_in   = '0;
                     rsp_reused_in = 1'b0;
                  end else if (block_count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_UNKNOWN;
                     rsp_addr_in   = '0;
                     rsp_reused_in = 1'b0;
                  end else begin
                     ptr_in      = '0;
                     tbl_rd_addr = '0;
                     state_in    = S_FSCAN;
                  end
               end
            end
         end

         S_ASCAN: begin
            if (cmp_res.ge) begin
               // First fit: the block leaves the free list and is marked in use.
               hit_in      = stk_rd_blk;
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = stk_rd_idx;
               tbl_wr_data = {1'b0, stk_rd_blk};
               if (ptr_nx1 < {1'b0, free_count_ff}) begin
                  stk_rd_addr = ptr_nx1[IDX_BITS-1:0];
                  state_in    = S_ASHIFT;
               end else begin
                  free_count_in = free_count_ff - 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_addr_in   = stk_rd_blk.addr + HEADER_ADDR;
                  rsp_reused_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (ptr_ff == '0) begin
               state_in = S_NEW;
            end else begin
               ptr_in      = ptr_ff - 1'b1;
               stk_rd_addr = ptr_ff - 1'b1;
            end
         end

         S_ASHIFT: begin
            // The entry above the write position arrived this cycle; move it down.
            stk_wr_en   = 1'b1;
            stk_wr_addr = ptr_ff;
            stk_wr_data = stk_rd_data;
            if (ptr_nx2 < {1'b0, free_count_ff}) begin
               stk_rd_addr = ptr_nx2[IDX_BITS-1:0];
               ptr_in      = ptr_nx1[IDX_BITS-1:0];
            end else begin
               free_count_in = free_count_ff - 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = hit_ff.addr + HEADER_ADDR;
               rsp_reused_in = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_NEW: begin
            if (block_count_ff >= MAX_CNT || size_ff[PTR_BITS-1]) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OOM;
               rsp_addr_in   = '0;
               rsp_reused_in = 1'b0;
               state_in      = S_IDLE;
            end else begin
               end_in   = CMP_BITS'(break_ff) + HEADER_CMP + CMP_BITS'(size_ff);
               limit_in = CMP_BITS'(base_ff) + CMP_BITS'(bytes_ff);
               state_in = S_NCHK;
            end
         end

         S_NCHK: begin
            rsp_valid_in  = 1'b1;
            rsp_reused_in = 1'b0;
            state_in      = S_IDLE;
            if (cmp_res.ge && end_ff <= ADDR_TOP) begin
               tbl_wr_en      = 1'b1;
               tbl_wr_addr    = block_count_ff[IDX_BITS-1:0];
               tbl_wr_data    = {1'b0, break_ff[DATA_BITS-1:0], size_ff[DATA_BITS-1:0]};
               block_count_in = block_count_ff + 1'b1;
               break_in       = end_ff[PTR_BITS-1:0];
               rsp_status_in  = ST_OK;
               rsp_addr_in    = break_ff[DATA_BITS-1:0] + HEADER_ADDR;
            end else begin
               rsp_status_in = ST_OOM;
               rsp_addr_in   = '0;
            end
         end

         S_FSCAN: begin
            if (cmp_res.eq) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_reused_in = 1'b0;
               state_in      = S_IDLE;
               if (tbl_rd_free) begin
                  rsp_status_in = ST_DOUBLE;
               end else begin
                  rsp_status_in = ST_OK;
                  if (free_count_ff < MAX_CNT) begin
                     tbl_wr_en     = 1'b1;
                     tbl_wr_addr   = ptr_ff;
                     tbl_wr_data   = {1'b1, tbl_rd_blk};
                     stk_wr_en     = 1'b1;
                     stk_wr_addr   = free_count_ff[IDX_BITS-1:0];
                     stk_wr_data   = {ptr_ff, tbl_rd_blk};
                     free_count_in = free_count_ff + 1'b1;
                  end
               end
            end else if (ptr_nx1 < {1'b0, block_count_ff}) begin
               ptr_in      = ptr_nx1[IDX_BITS-1:0];
               tbl_rd_addr = ptr_nx1[IDX_BITS-1:0];
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_UNKNOWN;
               rsp_addr_in   = '0;
               rsp_reused_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         block_count_ff <= '0;
         free_count_ff  <= '0;
         base_ff        <= '0;
         bytes_ff       <= '0;
         break_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         free_count_ff  <= free_count_in;
         base_ff        <= base_in;
         bytes_ff       <= bytes_in;
         break_ff       <= break_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      uaddr_ff      <= uaddr_in;
      ptr_ff        <= ptr_in;
      hit_ff        <= hit_in;
      end_ff        <= end_in;
      limit_ff      <= limit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_reused_ff <= rsp_reused_in;
   end

   // A register write and a request never share an edge, so a request always
   // sees either the old heap or the freshly emptied one, never a mix.
   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = ~busy & ~start;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_reused      = rsp_reused_ff;

   // Every accepted request is either answered at once or keeps the block busy.
   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither answered nor in progress");

   // The sequencer only returns to idle together with a response.
   a_idle_with_rsp: assert property (@(posedge clock) disable iff (reset)
      ($past(busy) && !busy) |-> rsp_valid)
      else $error("sequencer went idle without a response");

   // Every free-stack entry names a distinct placed block, so the free count never exceeds the block count.
   a_free_le_blocks: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff <= block_count_ff))
      else $error("free stack holds more entries than placed blocks");

   a_blocks_bounded: assert property (@(posedge clock) disable iff (reset)
      (block_count_ff <= MAX_CNT))
      else $error("block count beyond table depth");

   // A reused block is only ever reported with a successful allocation.
   a_reuse_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reused) |-> (rsp_status == ST_OK && rsp_result_addr != '0
                                     || rsp_status == ST_OK))
      else $error("reuse flag on a failed response");

endmodule
